### rtl/hsw_pkg.sv
// Shared types, field widths, register codes and the 1/h table for the harmonic sum block.
// No dependencies; every file in rtl/ but hsw_divider imports this package.

package hsw_pkg;

	localparam int INDEX_W    = 12;  // sample_index
	localparam int SAMPLE_W   = 18;  // sample_value, signed Q3.14
	localparam int PERIOD_W   = 13;  // period_length register
	localparam int HCOUNT_W   = 5;   // harmonic_count register
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int SINE_W     = 16;  // signed Q1.14 sine word
	localparam int MAG_W      = 15;  // |sine| up to 16384
	localparam int RECIP_W    = 17;  // unsigned Q1.16, 1/1 = 65536
	localparam int PROD_W     = MAG_W + RECIP_W;
	localparam int TERM_W     = 15;  // rounded term up to 16384
	localparam int ACC_W      = 21;  // 31 terms of 16384 plus sign

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
	localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = HCOUNT_W'(5);

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_COUNT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [PERIOD_W-1:0] period_length;
		logic [HCOUNT_W-1:0] harmonic_count;
	} hsw_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN,
		ST_FIN
	} hsw_state_t;

	// floor((65536 + floor(h/2)) / h)
	function automatic logic [RECIP_W-1:0] recip(input logic [HCOUNT_W-1:0] h);
		logic [RECIP_W-1:0] r;
		case (h)
			5'd1:    r = 17'd65536;
			5'd2:    r = 17'd32768;
			5'd3:    r = 17'd21845;
			5'd4:    r = 17'd16384;
			5'd5:    r = 17'd13107;
			5'd6:    r = 17'd10923;
			5'd7:    r = 17'd9362;
			5'd8:    r = 17'd8192;
			5'd9:    r = 17'd7282;
			5'd10:   r = 17'd6554;
			5'd11:   r = 17'd5958;
			5'd12:   r = 17'd5461;
			5'd13:   r = 17'd5041;
			5'd14:   r = 17'd4681;
			5'd15:   r = 17'd4369;
			5'd16:   r = 17'd4096;
			5'd17:   r = 17'd3855;
			5'd18:   r = 17'd3641;
			5'd19:   r = 17'd3449;
			5'd20:   r = 17'd3277;
			5'd21:   r = 17'd3121;
			5'd22:   r = 17'd2979;
			5'd23:   r = 17'd2849;
			5'd24:   r = 17'd2731;
			5'd25:   r = 17'd2621;
			5'd26:   r = 17'd2521;
			5'd27:   r = 17'd2427;
			5'd28:   r = 17'd2341;
			5'd29:   r = 17'd2260;
			5'd30:   r = 17'd2185;
			5'd31:   r = 17'd2114;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/hsw_if.sv
// Handshake interfaces for the index, sample and configuration channels.
// Depends on hsw_pkg for the field widths.

interface hsw_index_if;
	import hsw_pkg::*;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] sample_index;
	modport source (output valid, output sample_index, input ready);
	modport sink   (input valid, input sample_index, output ready);
endinterface

interface hsw_sample_if;
	import hsw_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       index_error;
	modport source (output valid, output sample_value, output index_error, input ready);
	modport sink   (input valid, input sample_value, input index_error, output ready);
endinterface

interface hsw_cfg_if;
	import hsw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/hsw_cfg_regs.sv
// Configuration register file: period length and harmonic count.
// Depends on hsw_pkg and hsw_cfg_if.

module hsw_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	hsw_cfg_if.sink           cfg,
	output hsw_pkg::hsw_cfg_t regs
);
	import hsw_pkg::*;

	hsw_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.period_length  <= PERIOD_RESET;
			regs_q.harmonic_count <= HCOUNT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PERIOD_LENGTH:  regs_q.period_length  <= cfg.data[PERIOD_W-1:0];
				REG_HARMONIC_COUNT: regs_q.harmonic_count <= cfg.data[HCOUNT_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

endmodule

### rtl/hsw_divider.sv
// Restoring divider, one quotient bit per cycle: quot = dividend / divisor.
// Stand-alone; the quotient must fit in QW bits (top bits of dividend below divisor).

module hsw_divider #(
	parameter  int QW = 10,
	parameter  int PW = 13,
	localparam int DW = PW + QW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [PW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [QW-1:0] quot,
	output logic [PW-1:0] rem
);
	localparam int CW = $clog2(QW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] div_q;
	logic [QW-1:0] shf_q;   // dividend bits out at the top, quotient bits in at the bottom
	logic [PW:0]   trial;
	logic          ge;

	assign trial = {rem_q, shf_q[QW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW-1:QW];
			shf_q <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? PW'(trial - {1'b0, div_q}) : PW'(trial);
			shf_q <= {shf_q[QW-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quot = shf_q;
	assign rem  = rem_q;

endmodule

### rtl/hsw_sine_rom.sv
// Full-cycle sine ROM, signed Q1.14, registered read port.
// Contents are built at elaboration from a Q4.28 Taylor series; depends on hsw_pkg.

module hsw_sine_rom #(
	parameter  int SINE_TABLE_SIZE = 1024,
	localparam int AW = $clog2(SINE_TABLE_SIZE)
) (
	input  logic                                clk,
	input  logic [AW-1:0]                       rd_addr,
	output logic signed [hsw_pkg::SINE_W-1:0]   rd_data
);
	import hsw_pkg::*;

	localparam longint Q28_TWO_PI  = 64'sd1686629713;
	localparam longint Q28_PI      = 64'sd843314857;
	localparam longint Q28_HALF_PI = 64'sd421657428;

	typedef logic signed [SINE_W-1:0] rom_t [SINE_TABLE_SIZE];

	// Fold the angle into the first quadrant, sum odd powers through x^13, round to Q1.14.
	function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned a);
		longint      x;
		logic [63:0] ux;
		logic [63:0] t;
		longint      sum;
		longint      q;
		logic        neg;
		x   = longint'((64'(a) * 64'(Q28_TWO_PI)) / 64'(SINE_TABLE_SIZE));
		neg = 1'b0;
		if (x >= Q28_PI) begin
			neg = 1'b1;
			x   = x - Q28_PI;
		end
		if (x > Q28_HALF_PI) x = Q28_PI - x;
		ux  = 64'(x);
		t   = ux;
		sum = x;
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd6;   sum = sum - longint'(t);
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd20;  sum = sum + longint'(t);
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd42;  sum = sum - longint'(t);
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd72;  sum = sum + longint'(t);
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd110; sum = sum - longint'(t);
		t = (t * ux) >> 28; t = (t * ux) >> 28; t = t / 64'd156; sum = sum + longint'(t);
		if (sum < 0) sum = 0;
		q = (sum + 64'sd8192) >>> 14;
		if (q > 64'sd16384) q = 64'sd16384;
		return neg ? SINE_W'(-q) : SINE_W'(q);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int unsigned a = 0; a < SINE_TABLE_SIZE; a++) begin
			r[a] = sine_entry(a);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		rd_data <= ROM[rd_addr];
	end

endmodule

### rtl/harmonic_sum_waveform.sv
// Top level of the additive-synthesis (sawtooth) sample generator.
// Depends on hsw_pkg, hsw_if, hsw_cfg_regs, hsw_divider and hsw_sine_rom.
//
// Channel        Dir   Handshake       Payload
// index_stream   in    valid/ready     sample_index [11:0]
// sample_stream  out   valid/ready     sample_value [17:0] signed Q3.14, index_error
// cfg            in    valid/ready     index [3:0], data [12:0]; 0 period, 1 harmonic count
//
// One item at a time. For each accepted index the one-bit-per-cycle divider
// first finds where the fundamental lands in the sine table (AW quotient bits;
// AW = log2 of the sine table size, 10 by default), then the harmonics go
// through the shared multiplier one harmonic per cycle, then the pipe drains.
// An out-of-range index skips all of that and goes straight to the final load.
// Reset (arst_n low) loads period 1000 and 5 harmonics and empties the pipe.
// A finished sample waits in the output register; a new index is taken as
// soon as the sequencer is idle, and only the final load stalls on the sink.

module harmonic_sum_waveform #(
	parameter int MAX_PERIOD      = 4096,
	parameter int MAX_HARMONICS   = 16,
	parameter int SINE_TABLE_SIZE = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	hsw_index_if.sink     index_stream,
	hsw_sample_if.source  sample_stream,
	hsw_cfg_if.sink       cfg
);
	import hsw_pkg::*;

	localparam int AW     = $clog2(SINE_TABLE_SIZE);
	localparam int PW_RAW = $clog2(MAX_PERIOD + 1);
	localparam int PW     = (PW_RAW < PERIOD_W) ? PW_RAW : PERIOD_W;
	localparam int HW_RAW = $clog2(MAX_HARMONICS + 1);
	localparam int HW     = (HW_RAW < HCOUNT_W) ? HW_RAW : HCOUNT_W;
	localparam int DW     = PW + AW;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(131071);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(131072);

	// ---------------------------------------------------------------
	// Configuration and effective limits
	// ---------------------------------------------------------------
	hsw_cfg_t regs;

	hsw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	logic [PERIOD_W-1:0] p_full;
	logic [PW-1:0]       p_eff;
	logic [HW-1:0]       hc_eff;

	// Clamp the period and count to what the hardware was sized for.
	assign p_full = (32'(regs.period_length) > MAX_PERIOD) ? PERIOD_W'(MAX_PERIOD)
	                                                       : regs.period_length;
	assign p_eff  = PW'(p_full);
	assign hc_eff = (32'(regs.harmonic_count) > MAX_HARMONICS) ? HW'(MAX_HARMONICS)
	                                                           : HW'(regs.harmonic_count);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	hsw_state_t state_q, state_nx;

	logic accept;
	logic idx_err;
	logic div_start;
	logic div_busy;
	logic div_done;
	logic issue;
	logic out_free;
	logic out_load;

	logic [AW-1:0] qn;   // floor(n * S / p)
	logic [PW-1:0] rn;   // n * S mod p

	logic          v_s1, v_s2;
	logic [HW-1:0] h_q;

	assign accept   = index_stream.valid && index_stream.ready;
	assign idx_err  = PERIOD_W'(index_stream.sample_index) >= p_full;
	assign out_free = !sample_stream.valid || sample_stream.ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nx = idx_err ? ST_FIN : ST_DIV;
			ST_DIV:  if (div_done) state_nx = ST_RUN;
			ST_RUN:  if (h_q == hc_eff) state_nx = ST_FIN;
			ST_FIN:  if (out_load) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		index_stream.ready = 1'b0;
		div_start          = 1'b0;
		issue              = 1'b0;
		out_load           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				index_stream.ready = 1'b1;
				div_start          = index_stream.valid && !idx_err;
			end
			ST_DIV: ;
			ST_RUN: issue = (h_q != hc_eff);
			// load only once the last term has reached the accumulator
			ST_FIN: out_load = !v_s1 && !v_s2 && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------------------------------------------------------
	// One division per in-range item: n * S / p. Every harmonic after that is
	// an add of quotient and remainder, since h*n*S/p grows by qn + rn/p.
	// ---------------------------------------------------------------
	logic [DW-1:0] dividend;

	assign dividend = DW'(PW'(index_stream.sample_index)) * DW'(SINE_TABLE_SIZE);

	hsw_divider #(
		.QW (AW),
		.PW (PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (p_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (qn),
		.rem      (rn)
	);

	// ---------------------------------------------------------------
	// Phase step: table address of harmonic h is floor(h*n*S/p) mod S
	// ---------------------------------------------------------------
	logic [AW-1:0] qacc_q;
	logic [PW-1:0] racc_q;
	logic [PW:0]   rsum;
	logic          rcarry;
	logic [PW-1:0] rnext;
	logic [AW:0]   qsum;
	logic [AW-1:0] qnext;
	logic [HW-1:0] h_next;

	assign rsum   = {1'b0, racc_q} + {1'b0, rn};
	assign rcarry = rsum >= {1'b0, p_eff};
	assign rnext  = rcarry ? PW'(rsum - {1'b0, p_eff}) : PW'(rsum);
	assign qsum   = {1'b0, qacc_q} + {1'b0, qn} + (AW+1)'(rcarry);
	assign qnext  = (qsum >= (AW+1)'(SINE_TABLE_SIZE)) ? AW'(qsum - (AW+1)'(SINE_TABLE_SIZE))
	                                                   : AW'(qsum);
	assign h_next = h_q + HW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (accept) begin
			h_q <= '0;
		end else if (issue) begin
			h_q <= h_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qacc_q <= '0;
			racc_q <= '0;
		end else if (issue) begin
			qacc_q <= qnext;
			racc_q <= rnext;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: sine ROM read and 1/h lookup
	// ---------------------------------------------------------------
	logic signed [SINE_W-1:0] sine_s1;
	logic [RECIP_W-1:0]       recip_s1;

	hsw_sine_rom #(
		.SINE_TABLE_SIZE (SINE_TABLE_SIZE)
	) u_rom (
		.clk     (clk),
		.rd_addr (qnext),
		.rd_data (sine_s1)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			recip_s1 <= recip(HCOUNT_W'(h_next));
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: magnitude times 1/h on the shared multiplier
	// ---------------------------------------------------------------
	logic [MAG_W-1:0]  mag;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;

	assign mag = sine_s1[SINE_W-1] ? MAG_W'(-sine_s1) : MAG_W'(sine_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(recip_s1);
			neg_s2  <= sine_s1[SINE_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// ---------------------------------------------------------------
	// Accumulate: round half away from zero, then add with the sine's sign
	// ---------------------------------------------------------------
	logic [PROD_W:0]          rounded;
	logic [TERM_W-1:0]        term;
	logic signed [ACC_W-1:0]  term_ext;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     err_q;

	assign rounded  = {1'b0, prod_s2} + (PROD_W+1)'(32768);
	assign term     = rounded[16 +: TERM_W];
	assign term_ext = ACC_W'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			acc_q <= '0;
			err_q <= idx_err;
		end else if (v_s2) begin
			acc_q <= neg_s2 ? acc_q - term_ext : acc_q + term_ext;
		end
	end

	// ---------------------------------------------------------------
	// Output register: saturate to Q3.14 and hold until taken
	// ---------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] sat;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic                       out_err_q;
	logic                       out_valid_q;

	always_comb begin
		if (acc_q > SAT_HI) begin
			sat = SAMPLE_W'(SAT_HI);
		end else if (acc_q < SAT_LO) begin
			sat = SAMPLE_W'(SAT_LO);
		end else begin
			sat = SAMPLE_W'(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (sample_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= sat;
			out_err_q   <= err_q;
		end
	end

	assign sample_stream.valid        = out_valid_q;
	assign sample_stream.sample_value = out_value_q;
	assign sample_stream.index_error  = out_err_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stream.valid && sample_stream.index_error |-> sample_stream.sample_value == '0)
		else $error("index error reported with a nonzero sample");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished while the sequencer was not waiting");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !v_s1 && !v_s2 && !div_busy)
		else $error("sample loaded while terms were still in flight");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> h_q <= hc_eff)
		else $error("harmonic counter ran past the harmonic count");

endmodule
